/* hw/rtl/timestamp_lower_bound_search_unit_macros.svh */
// assertion macros for the timestamp lower bound search unit
// used by the modules that carry concurrent checks; expects clk and rst in scope
`ifndef TIMESTAMP_LOWER_BOUND_SEARCH_UNIT_MACROS_SVH
`define TIMESTAMP_LOWER_BOUND_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLBS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TLBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/tlbs_pkg.sv */
// shared types and constants for the timestamp lower bound search unit
// no dependencies
`timescale 1ns / 1ps

package tlbs_pkg;

  localparam int COUNT_W = 13;
  localparam int POS_W   = 12;
  localparam int TIME_W  = 64;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic              func;
    logic [POS_W-1:0]  position;
    logic [TIME_W-1:0] time_value;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] found_index;
    logic               exact_hit;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/tlbs_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module tlbs_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/tlbs_ctrl.sv */
// search sequencer: table memory, load writes and the halving search loop
// depends on tlbs_pkg, tlbs_ram and the assertion macro header
`timescale 1ns / 1ps
`include "timestamp_lower_bound_search_unit_macros.svh"

module tlbs_ctrl import tlbs_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  in_item_t           item,
  input  logic [COUNT_W-1:0] event_count,
  output logic               res_valid,
  input  logic               res_take,
  output out_item_t          res
);

  localparam int AW = $clog2(TABLE_DEPTH);

  state_t state, state_next;

  logic [COUNT_W-1:0] lo, hi, mid;
  logic               hit;
  logic [TIME_W-1:0]  t_q;

  logic               accept;
  logic               is_query;
  logic [COUNT_W-1:0] n_eff;
  logic [COUNT_W-1:0] lo_step, hi_step, mid_step;
  logic               hit_step;
  logic               step_more;
  logic [31:0]        pos_wide;
  logic [31:0]        mid_wide;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [TIME_W-1:0]  ram_rdata;

  // datapath
  always_comb begin
    accept   = item_valid && (state == ST_IDLE);
    is_query = (item.func == FUNC_QUERY);
    n_eff    = (32'(event_count) > 32'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : event_count;

    if (ram_rdata < t_q) begin
      lo_step  = COUNT_W'(mid + 1'b1);
      hi_step  = hi;
      hit_step = hit;
    end else begin
      lo_step  = lo;
      hi_step  = mid;
      hit_step = (ram_rdata == t_q);
    end
    mid_step  = lo_step + ((hi_step - lo_step) >> 1);
    step_more = (lo_step < hi_step);

    pos_wide  = 32'(item.position);
    mid_wide  = (state == ST_IDLE) ? 32'(n_eff >> 1) : 32'(mid_step);
    ram_waddr = pos_wide[AW-1:0];
    ram_raddr = mid_wide[AW-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && is_query) begin
          state_next = (n_eff == '0) ? ST_DONE : ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = step_more ? ST_STEP : ST_DONE;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item_stall = 1'b1;
    res_valid  = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        ram_we     = accept && !is_query && (pos_wide < 32'(TABLE_DEPTH));
        ram_re     = accept && is_query && (n_eff != '0);
      end
      ST_STEP: begin
        ram_re = step_more;
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: item_stall = 1'b1;
    endcase
    res.found_index = hi;
    res.exact_hit   = hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      if (accept && is_query) begin
        lo  <= '0;
        hi  <= n_eff;
        mid <= n_eff >> 1;
        hit <= 1'b0;
        t_q <= item.time_value;
      end
    end else if (state == ST_STEP) begin
      lo  <= lo_step;
      hi  <= hi_step;
      mid <= mid_step;
      hit <= hit_step;
    end
  end

  tlbs_ram #(
    .Width(TIME_W),
    .Depth(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(item.time_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  `TLBS_ASSERT(a_step_open, state == ST_STEP, lo < hi, "search window empty while stepping")
  `TLBS_ASSERT(a_done_closed, state == ST_DONE, lo == hi, "search window not closed at done")
  `TLBS_ASSERT_NEXT(a_read_lands, ram_re, state == ST_STEP, "table read with no step to use it")
  `TLBS_ASSERT_NEXT(a_hi_shrinks, state == ST_STEP, hi <= $past(hi), "upper bound grew")

endmodule

/* hw/rtl/timestamp_lower_bound_search_unit.sv */
// A load transfer writes its timestamp straight into the table memory when it is accepted;
// loads to positions at or beyond TABLE_DEPTH are dropped. A query transfer runs a binary
// lower-bound search with one table memory read per halving step over the first n entries,
// where n is event_count capped at TABLE_DEPTH. It passes through the accept, the halving
// steps and the move of the result into the output register; the step count depends on the
// search path. The single registered memory read port paces the steps. Only one item is in
// work at a time; a finished result waits in the output register while the next item is
// taken. Table entries come up undefined and the block does not clear them.
// top level; depends on tlbs_pkg and tlbs_ctrl
`timescale 1ns / 1ps

module timestamp_lower_bound_search_unit import tlbs_pkg::*; #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               count_we,
  input  logic [COUNT_W-1:0] count_wdata,
  input  logic               item_valid,
  output logic               item_stall,
  input  in_item_t           item,
  output logic               result_valid,
  input  logic               result_stall,
  output out_item_t          result
);

  logic [COUNT_W-1:0] event_count;
  logic               res_valid;
  logic               res_take;
  out_item_t          res;

  always_ff @(posedge clk) begin
    if (rst) begin
      event_count <= '0;
    end else if (count_we) begin
      event_count <= count_wdata;
    end
  end

  // output register frees when empty or drained this cycle
  assign res_take = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      result <= res;
    end
  end

  tlbs_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .event_count(event_count),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

endmodule

/* dv/timestamp_lower_bound_search_unit_tb.sv */
// self-checking testbench for timestamp_lower_bound_search_unit: directed rows, then random phases
// keeps its own timestamp table and lower-bound search to predict each query result that the plan does not give
// depends on tlbs_pkg and the unit rtl
`timescale 1ns / 1ps

module timestamp_lower_bound_search_unit_tb;
  import tlbs_pkg::*;

  localparam int TABLE_DEPTH = 4096;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES = 24;
  localparam int ITEMS_PER_PHASE = 32;
  localparam int SMALL_SPAN = 48;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic {ROW_ITEM, ROW_COUNT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    in_item_t           it;
    logic [COUNT_W-1:0] count;
    bit                 known;
    out_item_t          want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               count_we = 1'b0;
  logic [COUNT_W-1:0] count_wdata = '0;
  logic               item_valid = 1'b0;
  logic               item_stall;
  in_item_t           item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  out_item_t          result;

  logic [TIME_W-1:0]  stamp_table [TABLE_DEPTH];
  bit                 written [TABLE_DEPTH];
  logic [COUNT_W-1:0] count_shadow = '0;
  out_item_t          due_results [$];
  plan_row_t          plan [$];
  out_item_t          oldest;
  int                 fail_count = 0;
  int                 src_idle_pct = 0;
  int                 sink_stall_pct = 0;
  bit                 hold_request = 1'b0;
  int                 hold_left = 0;

  timestamp_lower_bound_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .count_we     (count_we),
    .count_wdata  (count_wdata),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #2 clk = ~clk;

  function automatic out_item_t lower_bound_of(input logic [TIME_W-1:0] t);
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    out_item_t   r;
    span = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
    lo = 0;
    hi = span;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (stamp_table[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    r.found_index = COUNT_W'(lo);
    r.exact_hit = (lo < span) && (stamp_table[lo] == t);
    return r;
  endfunction

  // first unwritten entry that a search for t would read, TABLE_DEPTH if none
  function automatic int unsigned first_gap(input logic [TIME_W-1:0] t);
    int unsigned span;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    span = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
    lo = 0;
    hi = span;
    while (lo < hi) begin
      mid = lo + ((hi - lo) >> 1);
      if (!written[mid]) return mid;
      if (stamp_table[mid] < t) lo = mid + 1;
      else hi = mid;
    end
    return TABLE_DEPTH;
  endfunction

  function automatic plan_row_t load_row(input int unsigned pos, input logic [TIME_W-1:0] t);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.it.func = FUNC_LOAD;
    r.it.position = POS_W'(pos);
    r.it.time_value = t;
    r.count = '0;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic plan_row_t query_row(input logic [TIME_W-1:0] t, input bit known,
                                          input int unsigned idx, input bit hit);
    plan_row_t r;
    r.kind = ROW_ITEM;
    r.it.func = FUNC_QUERY;
    r.it.position = '0;
    r.it.time_value = t;
    r.count = '0;
    r.known = known;
    r.want.found_index = COUNT_W'(idx);
    r.want.exact_hit = hit;
    return r;
  endfunction

  function automatic plan_row_t count_row(input int unsigned n);
    plan_row_t r;
    r.kind = ROW_COUNT;
    r.it = '0;
    r.count = COUNT_W'(n);
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic in_item_t random_item();
    in_item_t          it;
    int unsigned       span;
    int unsigned       p;
    int unsigned       pick;
    int unsigned       gap;
    logic [TIME_W-1:0] lo_t;
    logic [TIME_W-1:0] hi_t;
    span = (count_shadow > TABLE_DEPTH) ? TABLE_DEPTH : count_shadow;
    it.position = POS_W'($urandom);
    it.time_value = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 10 && span != 0) begin
      // load that keeps the order: a value between the neighbours
      it.func = FUNC_LOAD;
      p = $urandom_range(0, span - 1);
      lo_t = (p == 0 || !written[p-1]) ? '0 : stamp_table[p-1];
      hi_t = (p == TABLE_DEPTH - 1 || !written[p+1]) ? TIME_MAX : stamp_table[p+1];
      case ($urandom_range(0, 2))
        0: it.time_value = lo_t;
        1: it.time_value = hi_t;
        default: it.time_value = lo_t + ((hi_t - lo_t) >> 1);
      endcase
      it.position = POS_W'(p);
    end else if (pick < 15) begin
      it.func = FUNC_LOAD;
    end else begin
      it.func = FUNC_QUERY;
      p = $urandom_range(0, (span == 0) ? 0 : span - 1);
      pick = $urandom_range(0, 5);
      if (pick == 4) begin
        it.time_value = $urandom_range(0, 1) ? TIME_MAX : '0;
      end else if (pick < 4 && written[p]) begin
        case (pick)
          0, 1: it.time_value = stamp_table[p];
          2: it.time_value = stamp_table[p] + 1;
          default: it.time_value = stamp_table[p] - 1;
        endcase
      end
      // a search that would reach an unwritten entry loads that entry instead
      gap = first_gap(it.time_value);
      if (gap < TABLE_DEPTH) begin
        it.func = FUNC_LOAD;
        it.position = POS_W'(gap);
      end
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit known, input out_item_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.func == FUNC_QUERY) begin
      due_results.push_back(known ? want : lower_bound_of(it.time_value));
    end else if (it.position < TABLE_DEPTH) begin
      stamp_table[it.position] = it.time_value;
      written[it.position] = 1'b1;
    end
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    // quiet gap before the count register changes
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] n);
    drain();
    count_we <= 1'b1;
    count_wdata <= n;
    @(negedge clk);
    count_we <= 1'b0;
    count_shadow = n;
  endtask

  task automatic load_ascending(input int unsigned n, input logic [TIME_W-1:0] base,
                                input int unsigned max_step);
    logic [TIME_W-1:0] t;
    in_item_t          it;
    t = base;
    for (int unsigned i = 0; i < n; i++) begin
      // one step in four repeats the previous timestamp
      if ($urandom_range(0, 3) != 0) t = t + $urandom_range(1, max_step);
      it.func = FUNC_LOAD;
      it.position = POS_W'(i);
      it.time_value = t;
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result transfer: found_index %0d exact_hit %0b",
                 $time, result.found_index, result.exact_hit);
        fail_count++;
      end else begin
        oldest = due_results.pop_front();
        if (result.found_index !== oldest.found_index) begin
          $display("%0t: found_index expected %0d actual %0d",
                   $time, oldest.found_index, result.found_index);
          fail_count++;
        end
        if (result.exact_hit !== oldest.exact_hit) begin
          $display("%0t: exact_hit expected %0b actual %0b",
                   $time, oldest.exact_hit, result.exact_hit);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned roll;
    // empty table
    plan.push_back(query_row('0, 1'b1, 0, 1'b0));
    plan.push_back(query_row(TIME_MAX, 1'b1, 0, 1'b0));
    plan.push_back(load_row(0, 64'd10));
    plan.push_back(load_row(1, 64'd20));
    plan.push_back(load_row(2, 64'd20));
    plan.push_back(load_row(3, 64'd20));
    plan.push_back(load_row(4, 64'd30));
    plan.push_back(load_row(5, TIME_MAX));
    // load past the count at the top position
    plan.push_back(load_row(TABLE_DEPTH - 1, '0));
    plan.push_back(count_row(6));
    plan.push_back(query_row('0, 1'b1, 0, 1'b0));
    plan.push_back(query_row(64'd20, 1'b1, 1, 1'b1));
    plan.push_back(query_row(64'd25, 1'b1, 4, 1'b0));
    plan.push_back(query_row(64'd10, 1'b1, 0, 1'b1));
    plan.push_back(query_row(TIME_MAX, 1'b1, 5, 1'b1));
    plan.push_back(query_row(TIME_MAX - 1, 1'b1, 5, 1'b0));
    plan.push_back(count_row(1));
    plan.push_back(query_row(64'd11, 1'b1, 1, 1'b0));
    plan.push_back(query_row(64'd10, 1'b1, 0, 1'b1));
    // out of order table
    plan.push_back(load_row(1, 64'd5));
    plan.push_back(count_row(3));
    plan.push_back(query_row(64'd7, 1'b0, 0, 1'b0));
    plan.push_back(query_row(64'd30, 1'b0, 0, 1'b0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_COUNT) write_count(plan[i].count);
      else send_item(plan[i].it, plan[i].known, plan[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 5)
        1: begin
          src_idle_pct = 53;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 53;
        end
        3: begin
          src_idle_pct = 29;
          sink_stall_pct = 29;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      case (phase)
        0: n = TABLE_DEPTH;
        1: n = (1 << COUNT_W) - 1;
        2: n = TABLE_DEPTH + 1;
        3: n = 0;
        default: begin
          roll = $urandom_range(0, 9);
          if (roll < 6) n = $urandom_range(1, SMALL_SPAN);
          else if (roll == 6) n = $urandom_range(SMALL_SPAN + 1, TABLE_DEPTH - 1);
          else if (roll == 7) n = TABLE_DEPTH;
          else if (roll == 8) n = $urandom_range(TABLE_DEPTH + 1, (1 << COUNT_W) - 1);
          else n = 0;
        end
      endcase
      write_count(COUNT_W'(n));
      if (n != 0 && n <= SMALL_SPAN && $urandom_range(0, 1) != 0) begin
        load_ascending(n, {$urandom, $urandom} >> 1, 1 << 16);
      end
      // long receiver hold while items keep coming
      if (phase == 5) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) send_item(random_item(), 1'b0, '0);
    end

    drain();
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("timestamp_lower_bound_search_unit regression: pass");
    end else begin
      $display("timestamp_lower_bound_search_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timestamp_lower_bound_search_unit regression: fail");
    $finish;
  end

endmodule
